// ===== rtl/sdfp_pkg.sv =====
// Shared types and constants for the structured-data field parser.
package sdfp_pkg;

    // Size of the name buffer that bounds the ID and parameter-name lengths
    localparam int NAME_BUFFER_SIZE = 256;

    // Length counters hold any value up to the buffer size
    localparam int LEN_W = $clog2(NAME_BUFFER_SIZE) + 1;
    // Sum of prefix, ID and name lengths plus one
    localparam int SUM_W = LEN_W + 2;

    localparam int PREFIX_W = 8;
    localparam int VLIMIT_W = 16;
    localparam int CFG_W    = 16;
    localparam int RES_MAX  = 3;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [0:0] {
        REG_PREFIX_LENGTH = 1'b0,
        REG_VALUE_LIMIT   = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_ID_START      = 4'd1,
        PH_ID            = 4'd2,
        PH_PNAME_START   = 4'd3,
        PH_PNAME         = 4'd4,
        PH_VALUE_START   = 4'd5,
        PH_UVALUE        = 4'd6,
        PH_QVALUE        = 4'd7,
        PH_AFTER_PARAM   = 4'd8,
        PH_AFTER_ELEMENT = 4'd9
    } phase_t;

    typedef enum logic [3:0] {
        EV_ID    = 4'd0,
        EV_NAME  = 4'd1,
        EV_VALUE = 4'd2,
        EV_EMPTY = 4'd3,
        EV_PEND  = 4'd4,
        EV_EEND  = 4'd5,
        EV_DONE  = 4'd6,
        EV_ERROR = 4'd7,
        EV_TRAIL = 4'd8
    } event_t;

    // Bytes allowed in an SD-ID or a parameter name
    function automatic logic is_name_char(input logic [7:0] b);
        return !b[7] && (b != CH_EQUAL) && (b != CH_SPACE) &&
               (b != CH_RBRACK) && (b != CH_QUOTE);
    endfunction

endpackage

// ===== rtl/structured_data_field_parser.sv =====
// Top level of the structured-data field parser: byte classifier and event queue.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | in_valid / in_ready    | data_byte, field_start, end_of_data
//  out     | output    | out_valid / out_ready  | event_kind, out_byte, last_of_run
//  cfg     | input     | cfg_wr_en (no wait)    | cfg_addr, cfg_wdata
//
//  Each input word lands in an input register and is then classified; its zero
//  to three events load a small event buffer that drains one per cycle while
//  out_ready is high. One event or none streams at one word per cycle unless the
//  output stalls. The input register refills in the cycle the buffer loads, so
//  a stalled output holds at most one word plus its events.
//  Reset puts the parser in idle and loads prefix_length 7, value_limit 255.
module structured_data_field_parser (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          field_start,
    input  logic                          end_of_data,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    event_kind,
    output logic [7:0]                    out_byte,
    output logic                          last_of_run,

    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_addr,
    input  logic [sdfp_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int LEN_W = sdfp_pkg::LEN_W;
    localparam int SUM_W = sdfp_pkg::SUM_W;
    localparam logic [LEN_W:0] NAME_ROOM =
        (LEN_W+1)'(sdfp_pkg::NAME_BUFFER_SIZE - 1);
    localparam logic [SUM_W-1:0] NAME_TOP = SUM_W'(sdfp_pkg::NAME_BUFFER_SIZE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [sdfp_pkg::PREFIX_W-1:0] prefix_reg;
    logic [sdfp_pkg::VLIMIT_W-1:0] vlimit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= sdfp_pkg::PREFIX_W'(7);
            vlimit_reg <= sdfp_pkg::VLIMIT_W'(255);
        end
        else if (cfg_wr_en)
        begin
            unique case (sdfp_pkg::cfg_reg_t'(cfg_addr))
                sdfp_pkg::REG_PREFIX_LENGTH: prefix_reg <= cfg_wdata[sdfp_pkg::PREFIX_W-1:0];
                sdfp_pkg::REG_VALUE_LIMIT:   vlimit_reg <= cfg_wdata[sdfp_pkg::VLIMIT_W-1:0];
                default:                     prefix_reg <= prefix_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_full_reg;
    logic [7:0] ib_reg;
    logic       ifs_reg;
    logic       ieod_reg;

    // Event buffer
    sdfp_pkg::event_t res_kind_reg [sdfp_pkg::RES_MAX];
    logic [7:0]       res_byte_reg [sdfp_pkg::RES_MAX];
    logic [1:0]       res_cnt_reg;
    logic [1:0]       res_idx_reg;

    logic out_fire;
    logic buf_last;
    logic proc;

    assign out_valid   = (res_cnt_reg != 2'd0);
    assign buf_last    = (res_idx_reg == (res_cnt_reg - 2'd1));
    assign out_fire    = out_valid && out_ready;
    // Classify the held word once the buffer is empty or drains its last event
    assign proc        = in_full_reg && (!out_valid || (out_fire && buf_last));
    assign in_ready    = !in_full_reg || proc;

    assign event_kind  = res_kind_reg[res_idx_reg];
    assign out_byte    = res_byte_reg[res_idx_reg];
    assign last_of_run = buf_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_full_reg <= 1'b1;
        else if (proc)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ib_reg   <= data_byte;
            ifs_reg  <= field_start;
            ieod_reg <= end_of_data;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    sdfp_pkg::phase_t              ph_reg, ph_next;
    logic [LEN_W-1:0]              idl_reg, idl_next;
    logic [LEN_W-1:0]              nml_reg, nml_next;
    logic [sdfp_pkg::VLIMIT_W-1:0] vl_reg, vl_next;
    logic                          esc_reg, esc_next;

    sdfp_pkg::event_t ev_kind [sdfp_pkg::RES_MAX];
    logic [7:0]       ev_byte [sdfp_pkg::RES_MAX];
    logic [1:0]       cnt_next;

    // Room left for ID and name bytes; a negative room counts as none
    logic [LEN_W:0]   id_room;
    logic [LEN_W:0]   nm_room;
    logic             id_fits;
    logic             id_first_ok;
    logic             nm_fits;
    logic             nm_first_ok;
    logic [SUM_W-1:0] id_sum;
    logic [SUM_W-1:0] nm_sum;
    logic             nc;

    assign id_room     = NAME_ROOM - (LEN_W+1)'(prefix_reg);
    assign nm_room     = NAME_ROOM - {1'b0, idl_reg};
    assign id_fits     = !id_room[LEN_W] && ({1'b0, idl_reg} < id_room);
    assign id_first_ok = !id_room[LEN_W] && (id_room != '0);
    assign nm_fits     = !nm_room[LEN_W] && ({1'b0, nml_reg} < nm_room);
    assign nm_first_ok = !nm_room[LEN_W] && (nm_room != '0);
    assign id_sum      = SUM_W'(prefix_reg) + SUM_W'(idl_reg) + SUM_W'(1);
    assign nm_sum      = id_sum + SUM_W'(nml_reg);
    assign nc          = sdfp_pkg::is_name_char(ib_reg);

    always_comb
    begin
        logic [1:0]                    n;
        logic [sdfp_pkg::VLIMIT_W-1:0] vcur;

        ph_next  = ph_reg;
        idl_next = idl_reg;
        nml_next = nml_reg;
        esc_next = esc_reg;
        vcur     = vl_reg;
        n        = 2'd0;
        for (int i = 0; i < sdfp_pkg::RES_MAX; i++)
        begin
            ev_kind[i] = sdfp_pkg::EV_DONE;
            ev_byte[i] = 8'h00;
        end

        if (ifs_reg)
        begin
            // Restart on a field start
            idl_next = '0;
            nml_next = '0;
            vcur     = '0;
            esc_next = 1'b0;
            if (ib_reg == sdfp_pkg::CH_DASH)
            begin
                ev_kind[n] = sdfp_pkg::EV_DONE; n = n + 2'd1;
                ph_next    = sdfp_pkg::PH_IDLE;
            end
            else if (ib_reg == sdfp_pkg::CH_LBRACK)
                ph_next = sdfp_pkg::PH_ID_START;
            else
            begin
                // Absent field: done, then the byte is trailing
                ev_kind[n] = sdfp_pkg::EV_DONE;  n = n + 2'd1;
                ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                ph_next    = sdfp_pkg::PH_IDLE;
            end
        end
        else
        begin
            case (ph_reg)
                sdfp_pkg::PH_ID_START:
                begin
                    if (nc && id_first_ok)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_ID; ev_byte[n] = ib_reg; n = n + 2'd1;
                        idl_next   = LEN_W'(1);
                        ph_next    = sdfp_pkg::PH_ID;
                    end
                    else
                    begin
                        ev_kind[n] = sdfp_pkg::EV_ERROR; n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_IDLE;
                    end
                end
                sdfp_pkg::PH_ID:
                begin
                    if (ib_reg == sdfp_pkg::CH_SPACE && id_sum < NAME_TOP)
                    begin
                        nml_next = '0;
                        ph_next  = sdfp_pkg::PH_PNAME_START;
                    end
                    else if (ib_reg == sdfp_pkg::CH_RBRACK)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_EMPTY; n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_EEND;  n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_AFTER_ELEMENT;
                    end
                    else if (ib_reg != sdfp_pkg::CH_SPACE && id_fits && nc)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_ID; ev_byte[n] = ib_reg; n = n + 2'd1;
                        idl_next   = idl_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ev_kind[n] = sdfp_pkg::EV_ERROR; n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_IDLE;
                    end
                end
                sdfp_pkg::PH_PNAME_START:
                begin
                    if (nc && nm_first_ok)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_NAME; ev_byte[n] = ib_reg; n = n + 2'd1;
                        nml_next   = LEN_W'(1);
                        ph_next    = sdfp_pkg::PH_PNAME;
                    end
                    else
                    begin
                        ev_kind[n] = sdfp_pkg::EV_ERROR; n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_IDLE;
                    end
                end
                sdfp_pkg::PH_PNAME:
                begin
                    if (ib_reg == sdfp_pkg::CH_EQUAL && nm_sum < NAME_TOP)
                        ph_next = sdfp_pkg::PH_VALUE_START;
                    else if (ib_reg != sdfp_pkg::CH_EQUAL && nm_fits && nc)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_NAME; ev_byte[n] = ib_reg; n = n + 2'd1;
                        nml_next   = nml_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ev_kind[n] = sdfp_pkg::EV_ERROR; n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_IDLE;
                    end
                end
                sdfp_pkg::PH_VALUE_START, sdfp_pkg::PH_UVALUE:
                begin
                    if (ph_reg == sdfp_pkg::PH_VALUE_START)
                    begin
                        vcur     = '0;
                        esc_next = 1'b0;
                    end
                    if (ph_reg == sdfp_pkg::PH_VALUE_START && ib_reg == sdfp_pkg::CH_QUOTE)
                        ph_next = sdfp_pkg::PH_QVALUE;
                    else if (ib_reg == sdfp_pkg::CH_SPACE)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_PEND; n = n + 2'd1;
                        nml_next   = '0;
                        ph_next    = sdfp_pkg::PH_PNAME_START;
                    end
                    else if (ib_reg == sdfp_pkg::CH_RBRACK)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_PEND; n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_EEND; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_AFTER_ELEMENT;
                    end
                    else
                    begin
                        // Keep the byte while under the value limit, else drop it
                        if (vcur < vlimit_reg)
                        begin
                            ev_kind[n] = sdfp_pkg::EV_VALUE; ev_byte[n] = ib_reg;
                            n          = n + 2'd1;
                            vcur       = vcur + sdfp_pkg::VLIMIT_W'(1);
                        end
                        ph_next = sdfp_pkg::PH_UVALUE;
                    end
                end
                sdfp_pkg::PH_QVALUE:
                begin
                    if (!esc_reg)
                    begin
                        if (ib_reg == sdfp_pkg::CH_BSLASH)
                            esc_next = 1'b1;
                        else if (ib_reg == sdfp_pkg::CH_QUOTE)
                        begin
                            ev_kind[n] = sdfp_pkg::EV_PEND; n = n + 2'd1;
                            ph_next    = sdfp_pkg::PH_AFTER_PARAM;
                        end
                        else if (ib_reg == sdfp_pkg::CH_RBRACK)
                        begin
                            // Bare bracket inside quotes is consumed by the error
                            ev_kind[n] = sdfp_pkg::EV_ERROR; n = n + 2'd1;
                            ph_next    = sdfp_pkg::PH_IDLE;
                        end
                        else if (vcur < vlimit_reg)
                        begin
                            ev_kind[n] = sdfp_pkg::EV_VALUE; ev_byte[n] = ib_reg;
                            n          = n + 2'd1;
                            vcur       = vcur + sdfp_pkg::VLIMIT_W'(1);
                        end
                    end
                    else
                    begin
                        // Unknown escape keeps its backslash
                        if (ib_reg != sdfp_pkg::CH_QUOTE && ib_reg != sdfp_pkg::CH_RBRACK &&
                            ib_reg != sdfp_pkg::CH_BSLASH && vcur < vlimit_reg)
                        begin
                            ev_kind[n] = sdfp_pkg::EV_VALUE; ev_byte[n] = sdfp_pkg::CH_BSLASH;
                            n          = n + 2'd1;
                            vcur       = vcur + sdfp_pkg::VLIMIT_W'(1);
                        end
                        if (vcur < vlimit_reg)
                        begin
                            ev_kind[n] = sdfp_pkg::EV_VALUE; ev_byte[n] = ib_reg;
                            n          = n + 2'd1;
                            vcur       = vcur + sdfp_pkg::VLIMIT_W'(1);
                        end
                        esc_next = 1'b0;
                    end
                end
                sdfp_pkg::PH_AFTER_PARAM:
                begin
                    if (ib_reg == sdfp_pkg::CH_SPACE)
                    begin
                        nml_next = '0;
                        ph_next  = sdfp_pkg::PH_PNAME_START;
                    end
                    else if (ib_reg == sdfp_pkg::CH_RBRACK)
                    begin
                        ev_kind[n] = sdfp_pkg::EV_EEND; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_AFTER_ELEMENT;
                    end
                    else
                    begin
                        ev_kind[n] = sdfp_pkg::EV_ERROR; n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_IDLE;
                    end
                end
                sdfp_pkg::PH_AFTER_ELEMENT:
                begin
                    if (ib_reg == sdfp_pkg::CH_LBRACK)
                    begin
                        idl_next = '0;
                        ph_next  = sdfp_pkg::PH_ID_START;
                    end
                    else
                    begin
                        ev_kind[n] = sdfp_pkg::EV_DONE;  n = n + 2'd1;
                        ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                        ph_next    = sdfp_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    // Outside a field every byte is trailing
                    ev_kind[n] = sdfp_pkg::EV_TRAIL; ev_byte[n] = ib_reg; n = n + 2'd1;
                    ph_next    = sdfp_pkg::PH_IDLE;
                end
            endcase
        end

        // End of message closes any open field
        if (ieod_reg && ph_next != sdfp_pkg::PH_IDLE)
        begin
            if (ph_next == sdfp_pkg::PH_AFTER_ELEMENT)
            begin
                ev_kind[n] = sdfp_pkg::EV_DONE; n = n + 2'd1;
            end
            else
            begin
                if (ph_next == sdfp_pkg::PH_UVALUE)
                begin
                    ev_kind[n] = sdfp_pkg::EV_PEND; n = n + 2'd1;
                end
                ev_kind[n] = sdfp_pkg::EV_ERROR; n = n + 2'd1;
            end
            ph_next = sdfp_pkg::PH_IDLE;
        end

        vl_next  = vcur;
        cnt_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= sdfp_pkg::PH_IDLE;
            idl_reg <= '0;
            nml_reg <= '0;
            vl_reg  <= '0;
            esc_reg <= 1'b0;
        end
        else if (proc)
        begin
            ph_reg  <= ph_next;
            idl_reg <= idl_next;
            nml_reg <= nml_next;
            vl_reg  <= vl_next;
            esc_reg <= esc_next;
        end
    end

    // ------------------------------------------------------------------
    // Event buffer: load on classify, advance on each output word
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= 2'd0;
            res_idx_reg <= 2'd0;
        end
        else if (proc)
        begin
            res_cnt_reg <= cnt_next;
            res_idx_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            if (buf_last)
            begin
                res_cnt_reg <= 2'd0;
                res_idx_reg <= 2'd0;
            end
            else
                res_idx_reg <= res_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            res_kind_reg <= ev_kind;
            res_byte_reg <= ev_byte;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (res_idx_reg < res_cnt_reg))
        else $error("event index past event count");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> (out_valid == ($past(cnt_next) != 2'd0)) && (res_idx_reg == 2'd0))
        else $error("event buffer not loaded from classified word");

    a_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idl_reg < LEN_W'(sdfp_pkg::NAME_BUFFER_SIZE))
        else $error("ID length beyond name buffer");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !proc) |=> in_full_reg && $stable(ib_reg))
        else $error("unclassified input word lost");

endmodule

// ===== bench/sdfp_event_checker.sv =====
// Event checker for the structured-data field parser: tracks the parse state and scores events.
module sdfp_event_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        field_start,
    input  logic                        end_of_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [3:0]                  event_kind,
    input  logic [7:0]                  out_byte,
    input  logic                        last_of_run,
    input  logic                        cfg_wr_en,
    input  logic [0:0]                  cfg_addr,
    input  logic [sdfp_pkg::CFG_W-1:0]  cfg_wdata,
    output int                          mismatches,
    output int                          events_owed
);

    typedef struct packed {
        sdfp_pkg::event_t kind;
        logic [7:0]       ch;
        logic             last;
    } sd_event_t;

    logic [sdfp_pkg::PREFIX_W-1:0] cfg_prefix;
    logic [sdfp_pkg::VLIMIT_W-1:0] cfg_vlimit;
    sdfp_pkg::phase_t              phase;
    logic [8:0]                    id_len;
    logic [8:0]                    name_len;
    logic [15:0]                   val_len;
    logic                          esc;

    sd_event_t           step_events [sdfp_pkg::RES_MAX];
    int                  step_count;
    sd_event_t           owed_events [$];
    int                  bad_count;

    function automatic logic sd_name_char(input logic [7:0] b);
        return (b < 8'h80) && (b != sdfp_pkg::CH_EQUAL) && (b != sdfp_pkg::CH_SPACE) &&
               (b != sdfp_pkg::CH_RBRACK) && (b != sdfp_pkg::CH_QUOTE);
    endfunction

    function automatic void add_event(input sdfp_pkg::event_t k, input logic [7:0] b);
        sd_event_t ev;
        if (step_count < sdfp_pkg::RES_MAX)
        begin
            ev.kind = k;
            ev.ch   = (k inside {sdfp_pkg::EV_ID, sdfp_pkg::EV_NAME, sdfp_pkg::EV_VALUE,
                                 sdfp_pkg::EV_TRAIL}) ? b : 8'h00;
            ev.last = 1'b0;
            step_events[step_count] = ev;
            step_count++;
        end
    endfunction

    function automatic void error_on(input logic consumed, input logic [7:0] b);
        add_event(sdfp_pkg::EV_ERROR, 8'h00);
        if (!consumed)
            add_event(sdfp_pkg::EV_TRAIL, b);
        phase = sdfp_pkg::PH_IDLE;
    endfunction

    function automatic void done_then_trail(input logic [7:0] b);
        add_event(sdfp_pkg::EV_DONE, 8'h00);
        add_event(sdfp_pkg::EV_TRAIL, b);
        phase = sdfp_pkg::PH_IDLE;
    endfunction

    function automatic void keep_value(input logic [7:0] b);
        if (val_len < cfg_vlimit)
        begin
            add_event(sdfp_pkg::EV_VALUE, b);
            val_len++;
        end
    endfunction

    function automatic void unquoted_byte(input logic [7:0] b);
        if (b == sdfp_pkg::CH_SPACE)
        begin
            add_event(sdfp_pkg::EV_PEND, 8'h00);
            name_len = '0;
            phase = sdfp_pkg::PH_PNAME_START;
        end
        else if (b == sdfp_pkg::CH_RBRACK)
        begin
            add_event(sdfp_pkg::EV_PEND, 8'h00);
            add_event(sdfp_pkg::EV_EEND, 8'h00);
            phase = sdfp_pkg::PH_AFTER_ELEMENT;
        end
        else
        begin
            keep_value(b);
            phase = sdfp_pkg::PH_UVALUE;
        end
    endfunction

    // Advance the parse state by one byte and queue the events it causes
    function automatic void parse_byte(input logic [7:0] b, input logic fs, input logic eod);
        int id_room;
        int name_room;
        id_room = sdfp_pkg::NAME_BUFFER_SIZE - 1 - int'(cfg_prefix);
        if (id_room < 0)
            id_room = 0;
        name_room = sdfp_pkg::NAME_BUFFER_SIZE - 1 - int'(id_len);
        if (name_room < 0)
            name_room = 0;
        step_count = 0;

        if (fs)
        begin
            id_len   = '0;
            name_len = '0;
            val_len  = '0;
            esc      = 1'b0;
            if (b == sdfp_pkg::CH_DASH)
            begin
                add_event(sdfp_pkg::EV_DONE, 8'h00);
                phase = sdfp_pkg::PH_IDLE;
            end
            else if (b == sdfp_pkg::CH_LBRACK)
                phase = sdfp_pkg::PH_ID_START;
            else
                done_then_trail(b);
        end
        else
        begin
            case (phase)
                sdfp_pkg::PH_ID_START:
                    if (sd_name_char(b) && id_room > 0)
                    begin
                        add_event(sdfp_pkg::EV_ID, b);
                        id_len = 9'd1;
                        phase = sdfp_pkg::PH_ID;
                    end
                    else
                        error_on(1'b0, b);
                sdfp_pkg::PH_ID:
                    if (b == sdfp_pkg::CH_SPACE)
                    begin
                        if (int'(cfg_prefix) + int'(id_len) + 1 >= sdfp_pkg::NAME_BUFFER_SIZE)
                            error_on(1'b0, b);
                        else
                        begin
                            name_len = '0;
                            phase = sdfp_pkg::PH_PNAME_START;
                        end
                    end
                    else if (b == sdfp_pkg::CH_RBRACK)
                    begin
                        add_event(sdfp_pkg::EV_EMPTY, 8'h00);
                        add_event(sdfp_pkg::EV_EEND, 8'h00);
                        phase = sdfp_pkg::PH_AFTER_ELEMENT;
                    end
                    else if (int'(id_len) < id_room && sd_name_char(b))
                    begin
                        add_event(sdfp_pkg::EV_ID, b);
                        id_len++;
                    end
                    else
                        error_on(1'b0, b);
                sdfp_pkg::PH_PNAME_START:
                    if (sd_name_char(b) && name_room > 0)
                    begin
                        add_event(sdfp_pkg::EV_NAME, b);
                        name_len = 9'd1;
                        phase = sdfp_pkg::PH_PNAME;
                    end
                    else
                        error_on(1'b0, b);
                sdfp_pkg::PH_PNAME:
                    if (b == sdfp_pkg::CH_EQUAL)
                    begin
                        if (int'(cfg_prefix) + int'(id_len) + int'(name_len) + 1
                            >= sdfp_pkg::NAME_BUFFER_SIZE)
                            error_on(1'b0, b);
                        else
                            phase = sdfp_pkg::PH_VALUE_START;
                    end
                    else if (int'(name_len) < name_room && sd_name_char(b))
                    begin
                        add_event(sdfp_pkg::EV_NAME, b);
                        name_len++;
                    end
                    else
                        error_on(1'b0, b);
                sdfp_pkg::PH_VALUE_START:
                begin
                    val_len = '0;
                    esc = 1'b0;
                    if (b == sdfp_pkg::CH_QUOTE)
                        phase = sdfp_pkg::PH_QVALUE;
                    else
                        unquoted_byte(b);
                end
                sdfp_pkg::PH_UVALUE:
                    unquoted_byte(b);
                sdfp_pkg::PH_QVALUE:
                    if (!esc)
                    begin
                        if (b == sdfp_pkg::CH_BSLASH)
                            esc = 1'b1;
                        else if (b == sdfp_pkg::CH_QUOTE)
                        begin
                            add_event(sdfp_pkg::EV_PEND, 8'h00);
                            phase = sdfp_pkg::PH_AFTER_PARAM;
                        end
                        else if (b == sdfp_pkg::CH_RBRACK)
                            error_on(1'b1, b);
                        else
                            keep_value(b);
                    end
                    else
                    begin
                        // only quote, bracket and backslash lose the backslash
                        if (b != sdfp_pkg::CH_QUOTE && b != sdfp_pkg::CH_RBRACK &&
                            b != sdfp_pkg::CH_BSLASH)
                            keep_value(sdfp_pkg::CH_BSLASH);
                        keep_value(b);
                        esc = 1'b0;
                    end
                sdfp_pkg::PH_AFTER_PARAM:
                    if (b == sdfp_pkg::CH_SPACE)
                    begin
                        name_len = '0;
                        phase = sdfp_pkg::PH_PNAME_START;
                    end
                    else if (b == sdfp_pkg::CH_RBRACK)
                    begin
                        add_event(sdfp_pkg::EV_EEND, 8'h00);
                        phase = sdfp_pkg::PH_AFTER_ELEMENT;
                    end
                    else
                        error_on(1'b0, b);
                sdfp_pkg::PH_AFTER_ELEMENT:
                    if (b == sdfp_pkg::CH_LBRACK)
                    begin
                        id_len = '0;
                        phase = sdfp_pkg::PH_ID_START;
                    end
                    else
                        done_then_trail(b);
                default:
                begin
                    add_event(sdfp_pkg::EV_TRAIL, b);
                    phase = sdfp_pkg::PH_IDLE;
                end
            endcase
        end

        if (eod && phase != sdfp_pkg::PH_IDLE)
        begin
            if (phase == sdfp_pkg::PH_AFTER_ELEMENT)
                add_event(sdfp_pkg::EV_DONE, 8'h00);
            else
            begin
                if (phase == sdfp_pkg::PH_UVALUE)
                    add_event(sdfp_pkg::EV_PEND, 8'h00);
                add_event(sdfp_pkg::EV_ERROR, 8'h00);
            end
            phase = sdfp_pkg::PH_IDLE;
        end

        if (step_count > 0)
            step_events[step_count-1].last = 1'b1;
        for (int i = 0; i < step_count; i++)
            owed_events.push_back(step_events[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sd_event_t exp_ev;
        if (!rst_n)
        begin
            cfg_prefix  = 8'd7;
            cfg_vlimit  = 16'd255;
            phase       = sdfp_pkg::PH_IDLE;
            id_len      = '0;
            name_len    = '0;
            val_len     = '0;
            esc         = 1'b0;
            bad_count   = 0;
            owed_events.delete();
            mismatches  <= 0;
            events_owed <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (sdfp_pkg::cfg_reg_t'(cfg_addr))
                    sdfp_pkg::REG_PREFIX_LENGTH:
                        cfg_prefix = cfg_wdata[sdfp_pkg::PREFIX_W-1:0];
                    sdfp_pkg::REG_VALUE_LIMIT:
                        cfg_vlimit = cfg_wdata[sdfp_pkg::VLIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                parse_byte(data_byte, field_start, end_of_data);
            if (out_valid && out_ready)
            begin
                if (owed_events.size() == 0)
                begin
                    if (bad_count < 10)
                        $display("%0t: event with nothing owed: kind %0d byte %02h last %0b",
                                 $time, event_kind, out_byte, last_of_run);
                    bad_count++;
                end
                else
                begin
                    exp_ev = owed_events.pop_front();
                    if (event_kind !== exp_ev.kind || out_byte !== exp_ev.ch ||
                        last_of_run !== exp_ev.last)
                    begin
                        if (bad_count < 10)
                            $display("%0t: exp kind/byte/last %0d/%02h/%0b, got %0d/%02h/%0b",
                                     $time, exp_ev.kind, exp_ev.ch, exp_ev.last,
                                     event_kind, out_byte, last_of_run);
                        bad_count++;
                    end
                end
            end
            mismatches  <= bad_count;
            events_owed <= owed_events.size();
        end
    end

endmodule

// ===== bench/structured_data_field_parser_tb.sv =====
// Testbench top for the structured-data field parser: stimulus, back-pressure and verdict.
module structured_data_field_parser_tb;

    // One input word: a raw byte plus its field and message markers
    typedef struct packed {
        logic [7:0] ch;
        logic       fs;
        logic       eod;
    } sd_word_t;

    // Cycles with no word moving on either channel before the run is called hung
    localparam int STALL_LIMIT = 4000;
    // Quiet cycles after the last owed event, covering words that cause no event
    localparam int QUIET_CYCLES = 12;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [7:0]                  data_byte;
    logic                        field_start;
    logic                        end_of_data;
    logic                        out_valid;
    logic                        out_ready;
    logic [3:0]                  event_kind;
    logic [7:0]                  out_byte;
    logic                        last_of_run;
    logic                        cfg_wr_en;
    logic [0:0]                  cfg_addr;
    logic [sdfp_pkg::CFG_W-1:0]  cfg_wdata;

    int                mismatches;
    int                events_owed;
    int                quiet_cycles;
    int                in_idle_pct;
    int                out_stall_pct;
    sd_word_t          field_words [$];

    structured_data_field_parser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .field_start (field_start),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    // Checker sits beside the block, predicting events from the words it sees accepted
    sdfp_event_checker u_event_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .field_start (field_start),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .events_owed (events_owed)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: drop ready at random, at the rate the current phase sets
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog: count cycles in which no word moves; give up past the limit
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** structured_data_field_parser: FAILED **");
            $finish;
        end
    end

    // Offer one word, with a random idle gap first; hold it until taken.
    // Valid is left high on return so back-to-back words see no bubble.
    task automatic send_word(input logic [7:0] c, input logic fs, input logic eod);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= c;
        field_start <= fs;
        end_of_data <= eod;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send a literal byte string; fs_first marks its first byte, eod_last its last
    task automatic send_text(input string s, input bit fs_first, input bit eod_last);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], fs_first && (i == 0), eod_last && (i == s.len() - 1));
    endtask

    // Wait until every owed event has come, then let stray work finish
    task automatic settle();
        repeat (2) @(posedge clk);
        while (events_owed != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; the prefix write carries junk in its upper byte
    task automatic set_config(input logic [7:0] pfx, input logic [15:0] vlim);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sdfp_pkg::REG_PREFIX_LENGTH;
        cfg_wdata <= {8'($urandom), pfx};
        @(posedge clk);
        cfg_addr  <= sdfp_pkg::REG_VALUE_LIMIT;
        cfg_wdata <= vlim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] rand_name_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c == sdfp_pkg::CH_EQUAL || c == sdfp_pkg::CH_RBRACK || c == sdfp_pkg::CH_QUOTE);
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] c);
        field_words.push_back('{ch: c, fs: 1'b0, eod: 1'b0});
    endfunction

    // Build one field: mostly well-formed elements with random content, then
    // an ending (end of data, trailing byte or nothing), then some noise.
    function automatic void build_field();
        int         pick;
        int         n_el;
        int         n_id;
        int         n_par;
        int         n_name;
        int         n_val;
        int         sel;
        int         idx;
        logic [7:0] c;
        field_words.delete();
        pick = $urandom_range(99);
        if (pick < 6)
            push_byte(sdfp_pkg::CH_DASH);
        else if (pick < 12)
        begin
            // absent field: anything but the nil mark or an opening bracket
            do
                c = 8'($urandom);
            while (c == sdfp_pkg::CH_DASH || c == sdfp_pkg::CH_LBRACK);
            push_byte(c);
        end
        else
        begin
            n_el = $urandom_range(1, 3);
            for (int e = 0; e < n_el; e++)
            begin
                push_byte(sdfp_pkg::CH_LBRACK);
                if ($urandom_range(9) == 0)
                    n_id = $urandom_range(7, 12);
                else
                    n_id = $urandom_range(1, 6);
                for (int j = 0; j < n_id; j++)
                    push_byte(rand_name_char());
                n_par = $urandom_range(0, 3);
                for (int k = 0; k < n_par; k++)
                begin
                    push_byte(sdfp_pkg::CH_SPACE);
                    n_name = $urandom_range(1, 5);
                    for (int j = 0; j < n_name; j++)
                        push_byte(rand_name_char());
                    push_byte(sdfp_pkg::CH_EQUAL);
                    n_val = $urandom_range(0, 5);
                    if ($urandom_range(1) == 0)
                    begin
                        // unquoted value; a leading quote would switch to quoted
                        for (int j = 0; j < n_val; j++)
                        begin
                            do
                                c = 8'($urandom);
                            while (c == sdfp_pkg::CH_SPACE || c == sdfp_pkg::CH_RBRACK ||
                                   (j == 0 && c == sdfp_pkg::CH_QUOTE));
                            push_byte(c);
                        end
                    end
                    else
                    begin
                        push_byte(sdfp_pkg::CH_QUOTE);
                        for (int j = 0; j < n_val; j++)
                        begin
                            sel = $urandom_range(39);
                            if (sel < 8)
                            begin
                                push_byte(sdfp_pkg::CH_BSLASH);
                                case ($urandom_range(3))
                                    0:       push_byte(sdfp_pkg::CH_QUOTE);
                                    1:       push_byte(sdfp_pkg::CH_RBRACK);
                                    2:       push_byte(sdfp_pkg::CH_BSLASH);
                                    default: push_byte(8'($urandom));
                                endcase
                            end
                            else if (sel == 39)
                                push_byte(sdfp_pkg::CH_RBRACK);  // bare bracket inside quotes
                            else
                            begin
                                do
                                    c = 8'($urandom);
                                while (c == sdfp_pkg::CH_QUOTE || c == sdfp_pkg::CH_BSLASH ||
                                       c == sdfp_pkg::CH_RBRACK);
                                push_byte(c);
                            end
                        end
                        push_byte(sdfp_pkg::CH_QUOTE);
                    end
                end
                push_byte(sdfp_pkg::CH_RBRACK);
            end
        end
        field_words[0].fs = 1'b1;

        pick = $urandom_range(99);
        if (pick < 35)
            field_words[field_words.size()-1].eod = 1'b1;
        else if (pick < 65)
        begin
            do
                c = 8'($urandom);
            while (c == sdfp_pkg::CH_LBRACK);
            push_byte(c);
        end

        if ($urandom_range(99) < 15)
        begin
            idx = $urandom_range(0, field_words.size() - 1);
            field_words[idx].ch = 8'($urandom);
        end
        if ($urandom_range(99) < 10)
        begin
            // cut the message short anywhere in the field
            idx = $urandom_range(0, field_words.size() - 1);
            while (field_words.size() > idx + 1)
                void'(field_words.pop_back());
            field_words[idx].eod = 1'b1;
        end
    endfunction

    initial
    begin
        int         sent;
        logic [7:0] pfx;
        logic [15:0] vlim;

        // Hold the stimulus inputs at known values from time zero
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        field_start   = 1'b0;
        end_of_data   = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = sdfp_pkg::REG_PREFIX_LENGTH;
        cfg_wdata     = '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset register values
        send_word(8'h00, 1'b0, 1'b0);              // byte before any field start
        send_text("-", 1'b1, 1'b0);                 // nil field
        send_word(8'hFF, 1'b1, 1'b0);              // absent field
        // quoted value with a kept and a dropped backslash, then a trailing byte
        send_text("[a x=\"\\q\\]\"]Z", 1'b1, 1'b0);
        send_text("[b]", 1'b1, 1'b1);               // empty element ending the data
        send_text("[c k=v", 1'b1, 1'b1);            // data ends in an unquoted value
        in_valid <= 1'b0;
        settle();

        // Random phases: each one picks a register setting and an idling mode
        for (int p = 0; p < 5; p++)
        begin
            case (p % 4)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 52; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 52; end
                default: begin in_idle_pct = 8;  out_stall_pct = 8;  end
            endcase
            case (p)
                0:       begin pfx = 8'd0;   vlim = 16'hFFFF; end
                1:       begin pfx = 8'd255; vlim = 16'd0;    end
                2:       begin pfx = 8'd250; vlim = 16'd3;    end
                3:       begin pfx = 8'($urandom_range(0, 255)); vlim = 16'($urandom_range(0, 6)); end
                default: begin pfx = 8'd7;   vlim = 16'd255;  end
            endcase
            set_config(pfx, vlim);

            sent = 0;
            while (sent < 20)
            begin
                build_field();
                foreach (field_words[i])
                    send_word(field_words[i].ch, field_words[i].fs, field_words[i].eod);
                sent += field_words.size();
            end
            in_valid <= 1'b0;
            settle();
        end

        if (mismatches == 0)
            $display("** structured_data_field_parser: PASSED **");
        else
            $display("** structured_data_field_parser: FAILED **");
        $finish;
    end

endmodule
